// ===== design/ght_pkg.sv =====
// shared types and constants of the grid hole aware tesselator
package ght_pkg;

   localparam int MAX_ROWS_DEF = 256;
   localparam int MAX_COLS_DEF = 256;

   localparam int CFG_W = 9;
   localparam int CFG_IDX_W = 3;
   localparam int IDX_W = 18;
   localparam int VTX_W = 16;

   localparam int DIV_CYCLES = 4;
   localparam int DIV_BITS_PER_CYCLE = 4;
   localparam int QUOT_W = DIV_CYCLES * DIV_BITS_PER_CYCLE;
   localparam int REM_W = 9;

   localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_ROW_FIRST = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_COL_FIRST = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_COL_STRIDE = 3'd5;
   localparam logic [CFG_IDX_W-1:0] REG_COLS_SAMPLED = 3'd6;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_CELL = 1'b1;

   localparam logic [1:0] PRIM_POINT = 2'd0;
   localparam logic [1:0] PRIM_LINE = 2'd1;
   localparam logic [1:0] PRIM_TRI = 2'd2;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
      logic [REM_W-1:0]  rem;
   } div_result_type;

endpackage

// ===== design/ght_div.sv =====
// iterative divider for the sampled cell number, four quotient bits per cycle
module ght_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ght_pkg::QUOT_W-1:0]    dividend,
   input  logic [ght_pkg::REM_W-1:0]     divisor,
   output ght_pkg::div_result_type       result
);

   localparam int CNT_W = $clog2(ght_pkg::DIV_CYCLES);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ght_pkg::DIV_CYCLES - 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [ght_pkg::QUOT_W-1:0]    quot_ff, quot_in;
   logic [ght_pkg::REM_W-1:0]     rem_ff, rem_in;
   logic [ght_pkg::REM_W-1:0]     div_ff, div_in;
   logic [ght_pkg::QUOT_W-1:0]    q_step;
   logic [ght_pkg::REM_W:0]       r_step;

   always_comb begin
      logic [ght_pkg::REM_W:0] t;
      q_step = quot_ff;
      r_step = {1'b0, rem_ff};
      for (int i = 0; i < ght_pkg::DIV_BITS_PER_CYCLE; i++) begin
         t = {r_step[ght_pkg::REM_W-1:0], q_step[ght_pkg::QUOT_W-1]};
         q_step = {q_step[ght_pkg::QUOT_W-2:0], 1'b0};
         if (t >= {1'b0, div_ff}) begin
            t = t - {1'b0, div_ff};
            q_step[0] = 1'b1;
         end
         r_step = t;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      quot_in = quot_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         quot_in = dividend;
         rem_in = '0;
         div_in = divisor;
      end else if (busy_ff) begin
         quot_in = q_step;
         rem_in = r_step[ght_pkg::REM_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign result.done = done_ff;
   assign result.quot = quot_ff;
   assign result.rem = rem_ff;

endmodule

// ===== design/grid_hole_aware_tesselator.sv =====
// top level: node flag memory, cell sequencer and primitive output register
//
// Load requests write one node flag and are taken one per cycle while no cell is at work.
// A cell request inside the grid is dispatched, goes through the radix-16 divider (four
// steps, then a completion flag) that splits the cell number into sampled row and column,
// the stride multiplies, the grid edge checks, eight reads of the single read port of the
// flag memory (four corners and four neighbors), the return of the last read, the choice
// of primitives and the hand-out of none, one or two of them, plus any wait on rsp_ready.
// A cell outside the grid leaves after the edge checks, and a cell of an empty grid or of
// zero sampled columns at dispatch. One request is buffered while another is at work, and
// a finished primitive waits in the output register while the next request is taken. The
// flag memory has no reset: every node must be loaded before a cell that reads it.
module grid_hole_aware_tesselator #(
   parameter int MAX_ROWS = ght_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = ght_pkg::MAX_COLS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_opcode,
   input  logic [15:0]                     req_node_index,
   input  logic                            req_node_defined,
   input  logic [15:0]                     req_cell_number,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_prim_kind,
   output logic [15:0]                     rsp_vertex_a,
   output logic [15:0]                     rsp_vertex_b,
   output logic [15:0]                     rsp_vertex_c,
   output logic                            rsp_last_of_cell,
   input  logic                            csr_we,
   input  logic [ght_pkg::CFG_IDX_W-1:0]   csr_index,
   input  logic [ght_pkg::CFG_W-1:0]       csr_wdata
);

   localparam int MAP_NODES = MAX_ROWS * MAX_COLS;
   localparam int AW = $clog2(MAP_NODES);
   localparam int IW = ght_pkg::IDX_W;
   localparam int VW = ght_pkg::VTX_W;

   localparam logic [2:0] RD_C11 = 3'd0;
   localparam logic [2:0] RD_C12 = 3'd1;
   localparam logic [2:0] RD_C21 = 3'd2;
   localparam logic [2:0] RD_C22 = 3'd3;
   localparam logic [2:0] RD_C01 = 3'd4;
   localparam logic [2:0] RD_C10 = 3'd5;
   localparam logic [2:0] RD_C02 = 3'd6;
   localparam logic [2:0] RD_C20 = 3'd7;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b00000001,
      ST_DIV    = 8'b00000010,
      ST_MUL    = 8'b00000100,
      ST_CHK    = 8'b00001000,
      ST_READ   = 8'b00010000,
      ST_DRAIN  = 8'b00100000,
      ST_DECIDE = 8'b01000000,
      ST_EMIT   = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   logic [8:0] grid_rows_ff, grid_cols_ff, cols_sampled_ff;
   logic [7:0] row_first_ff, row_stride_ff, col_first_ff, col_stride_ff;
   logic [8:0] gr, gc, lastr, lastc;

   logic        pend_valid_ff, pend_valid_in;
   logic        pend_op_ff;
   logic [15:0] pend_node_ff;
   logic        pend_def_ff;
   logic [15:0] pend_cell_ff;
   logic        take;

   logic map_ff [MAP_NODES];
   logic map_q_ff;
   logic map_we;
   logic [AW-1:0] waddr, raddr;
   logic [31:0] waddr_full, raddr_full;

   logic div_start;
   ght_pkg::div_result_type div_res;

   logic [24:0] row_full_ff, row_full_in;
   logic [17:0] col_full_ff, col_full_in;
   logic [23:0] row_prod;
   logic [16:0] col_prod;

   logic [8:0] row_ff, col_ff, nrow_ff, ncol_ff, prow_ff, pcol_ff;
   logic [8:0] row_c, col_c, nrow_c, ncol_c, prow_c, pcol_c;
   logic [9:0] nrow_sum, ncol_sum;
   logic       lrow_ff, lcol_ff, hpr_ff, hpc_ff, in_range;

   logic [2:0]    step_ff, step_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [2:0]    rd_step_ff;
   logic [8:0]    rsel, csel;
   logic [17:0]   sel_prod;
   logic [18:0]   sel_sum;
   logic [IW-1:0] rd_idx;
   logic [IW-1:0] corner_ff [4];
   logic [7:0]    flags_ff;

   logic d11, d12, d21, d22, d01, d10, d02, d20;
   logic [2:0] ndef;
   logic [1:0] num_c, num_ff;
   logic [1:0] kind_c [2];
   logic [IW-1:0] va_c [2], vb_c [2], vc_c [2];
   logic [1:0] kind_ff [2];
   logic [VW-1:0] va_ff [2], vb_ff [2], vc_ff [2];
   logic       emit_idx_ff, emit_idx_in;
   logic       rsp_load, emit_last;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_kind_ff;
   logic [15:0] rsp_a_ff, rsp_b_ff, rsp_c_ff;
   logic        rsp_last_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= 9'd256;
         grid_cols_ff <= 9'd256;
         row_first_ff <= 8'd0;
         row_stride_ff <= 8'd1;
         col_first_ff <= 8'd0;
         col_stride_ff <= 8'd1;
         cols_sampled_ff <= 9'd256;
      end else if (csr_we) begin
         case (csr_index)
            ght_pkg::REG_GRID_ROWS:    grid_rows_ff <= csr_wdata;
            ght_pkg::REG_GRID_COLS:    grid_cols_ff <= csr_wdata;
            ght_pkg::REG_ROW_FIRST:    row_first_ff <= csr_wdata[7:0];
            ght_pkg::REG_ROW_STRIDE:   row_stride_ff <= csr_wdata[7:0];
            ght_pkg::REG_COL_FIRST:    col_first_ff <= csr_wdata[7:0];
            ght_pkg::REG_COL_STRIDE:   col_stride_ff <= csr_wdata[7:0];
            ght_pkg::REG_COLS_SAMPLED: cols_sampled_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign gr = (32'(grid_rows_ff) > MAX_ROWS) ? 9'(MAX_ROWS) : grid_rows_ff;
   assign gc = (32'(grid_cols_ff) > MAX_COLS) ? 9'(MAX_COLS) : grid_cols_ff;
   assign lastr = gr - 9'd1;
   assign lastc = gc - 9'd1;

   // request buffer
   assign take = pend_valid_ff && (state_ff == ST_IDLE);
   assign req_ready = !pend_valid_ff || take;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (req_valid && req_ready) begin
         pend_valid_in = 1'b1;
      end else if (take) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
      if (req_valid && req_ready) begin
         pend_op_ff <= req_opcode;
         pend_node_ff <= req_node_index;
         pend_def_ff <= req_node_defined;
         pend_cell_ff <= req_cell_number;
      end
   end

   // flag memory
   assign waddr_full = 32'(pend_node_ff);
   assign waddr = waddr_full[AW-1:0];
   assign map_we = take && (pend_op_ff == ght_pkg::OP_LOAD) && (waddr_full < MAP_NODES);
   assign raddr_full = 32'(rd_idx);
   assign raddr = raddr_full[AW-1:0];

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_ff[waddr] <= pend_def_ff;
      end
      map_q_ff <= map_ff[raddr];
   end

   // divider
   assign div_start = take && (pend_op_ff == ght_pkg::OP_CELL) &&
                      (gr != 9'd0) && (gc != 9'd0) && (cols_sampled_ff != 9'd0);

   ght_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (pend_cell_ff),
      .divisor  (cols_sampled_ff),
      .result   (div_res)
   );

   // strides and edges
   assign row_prod = 24'(div_res.quot) * 24'(row_stride_ff);
   assign col_prod = 17'(div_res.rem) * 17'(col_stride_ff);
   assign row_full_in = 25'(row_prod) + 25'(row_first_ff);
   assign col_full_in = 18'(col_prod) + 18'(col_first_ff);

   assign in_range = (row_full_ff <= 25'(lastr)) && (col_full_ff <= 18'(lastc));
   assign row_c = row_full_ff[8:0];
   assign col_c = col_full_ff[8:0];
   assign nrow_sum = 10'(row_c) + 10'(row_stride_ff);
   assign ncol_sum = 10'(col_c) + 10'(col_stride_ff);
   assign nrow_c = (nrow_sum > 10'(lastr)) ? lastr : nrow_sum[8:0];
   assign ncol_c = (ncol_sum > 10'(lastc)) ? lastc : ncol_sum[8:0];
   assign prow_c = (row_c >= 9'(row_stride_ff)) ? row_c - 9'(row_stride_ff) : 9'd0;
   assign pcol_c = (col_c >= 9'(col_stride_ff)) ? col_c - 9'(col_stride_ff) : 9'd0;

   // read address
   always_comb begin
      case (step_ff)
         RD_C11: begin rsel = row_ff;  csel = col_ff;  end
         RD_C12: begin rsel = row_ff;  csel = ncol_ff; end
         RD_C21: begin rsel = nrow_ff; csel = col_ff;  end
         RD_C22: begin rsel = nrow_ff; csel = ncol_ff; end
         RD_C01: begin rsel = prow_ff; csel = col_ff;  end
         RD_C10: begin rsel = row_ff;  csel = pcol_ff; end
         RD_C02: begin rsel = prow_ff; csel = ncol_ff; end
         RD_C20: begin rsel = nrow_ff; csel = pcol_ff; end
         default: begin rsel = row_ff; csel = col_ff; end
      endcase
   end

   assign sel_prod = 18'(rsel) * 18'(gc);
   assign sel_sum = 19'(sel_prod) + 19'(csel);
   assign rd_idx = sel_sum[IW-1:0];

   // primitive choice
   assign d11 = flags_ff[RD_C11];
   assign d12 = !lcol_ff && flags_ff[RD_C12];
   assign d21 = !lrow_ff && flags_ff[RD_C21];
   assign d22 = !lrow_ff && !lcol_ff && flags_ff[RD_C22];
   assign d01 = hpr_ff && flags_ff[RD_C01];
   assign d10 = hpc_ff && flags_ff[RD_C10];
   assign d02 = hpr_ff && !lcol_ff && flags_ff[RD_C02];
   assign d20 = !lrow_ff && hpc_ff && flags_ff[RD_C20];
   assign ndef = 3'(d11) + 3'(d12) + 3'(d21) + 3'(d22);

   always_comb begin
      num_c = 2'd0;
      for (int i = 0; i < 2; i++) begin
         kind_c[i] = ght_pkg::PRIM_TRI;
         va_c[i] = '0;
         vb_c[i] = '0;
         vc_c[i] = '0;
      end
      if (ndef == 3'd4) begin
         num_c = 2'd2;
         va_c[0] = corner_ff[2]; vb_c[0] = corner_ff[3]; vc_c[0] = corner_ff[0];
         va_c[1] = corner_ff[0]; vb_c[1] = corner_ff[3]; vc_c[1] = corner_ff[1];
      end else if (ndef == 3'd3) begin
         num_c = 2'd1;
         if (!d11) begin
            va_c[0] = corner_ff[2]; vb_c[0] = corner_ff[3]; vc_c[0] = corner_ff[1];
         end else if (!d12) begin
            va_c[0] = corner_ff[2]; vb_c[0] = corner_ff[3]; vc_c[0] = corner_ff[0];
         end else if (!d21) begin
            va_c[0] = corner_ff[0]; vb_c[0] = corner_ff[3]; vc_c[0] = corner_ff[1];
         end else begin
            va_c[0] = corner_ff[0]; vb_c[0] = corner_ff[2]; vc_c[0] = corner_ff[1];
         end
      end else if (d11) begin
         if (ndef == 3'd1) begin
            if (!d01 && !d10) begin
               num_c = 2'd1;
               kind_c[0] = ght_pkg::PRIM_POINT;
               va_c[0] = corner_ff[0];
            end
         end else if (d12 && !d01) begin
            if (!d02) begin
               num_c = 2'd1;
               kind_c[0] = ght_pkg::PRIM_LINE;
               va_c[0] = corner_ff[0]; vb_c[0] = corner_ff[1];
            end
         end else if (d21 && !d10) begin
            if (!d20) begin
               num_c = 2'd1;
               kind_c[0] = ght_pkg::PRIM_LINE;
               va_c[0] = corner_ff[0]; vb_c[0] = corner_ff[2];
            end
         end
      end
   end

   // sequencer
   assign rsp_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign emit_last = (2'(emit_idx_ff) + 2'd1) == num_ff;

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      rd_vld_in = 1'b0;
      emit_idx_in = emit_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (div_start) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: state_in = ST_CHK;
         ST_CHK: begin
            step_in = RD_C11;
            state_in = in_range ? ST_READ : ST_IDLE;
         end
         ST_READ: begin
            rd_vld_in = 1'b1;
            step_in = step_ff + 3'd1;
            if (step_ff == RD_C20) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_DECIDE;
         ST_DECIDE: begin
            emit_idx_in = 1'b0;
            state_in = (num_c == 2'd0) ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_load) begin
               emit_idx_in = 1'b1;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rd_vld_ff <= 1'b0;
         step_ff <= RD_C11;
         emit_idx_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rd_vld_ff <= rd_vld_in;
         step_ff <= step_in;
         emit_idx_ff <= emit_idx_in;
      end
      if (state_ff == ST_MUL) begin
         row_full_ff <= row_full_in;
         col_full_ff <= col_full_in;
      end
      if (state_ff == ST_CHK) begin
         row_ff <= row_c;
         col_ff <= col_c;
         nrow_ff <= nrow_c;
         ncol_ff <= ncol_c;
         prow_ff <= prow_c;
         pcol_ff <= pcol_c;
         lrow_ff <= row_c == lastr;
         lcol_ff <= col_c == lastc;
         hpr_ff <= row_c >= 9'(row_stride_ff);
         hpc_ff <= col_c >= 9'(col_stride_ff);
      end
      if (state_ff == ST_READ) begin
         rd_step_ff <= step_ff;
         if (!step_ff[2]) begin
            corner_ff[step_ff[1:0]] <= rd_idx;
         end
      end
      if (rd_vld_ff) begin
         flags_ff[rd_step_ff] <= map_q_ff;
      end
      if (state_ff == ST_DECIDE) begin
         num_ff <= num_c;
         for (int i = 0; i < 2; i++) begin
            kind_ff[i] <= kind_c[i];
            va_ff[i] <= va_c[i][VW-1:0];
            vb_ff[i] <= vb_c[i][VW-1:0];
            vc_ff[i] <= vc_c[i][VW-1:0];
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_kind_ff <= kind_ff[emit_idx_ff];
         rsp_a_ff <= va_ff[emit_idx_ff];
         rsp_b_ff <= vb_ff[emit_idx_ff];
         rsp_c_ff <= vc_ff[emit_idx_ff];
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_prim_kind = rsp_kind_ff;
   assign rsp_vertex_a = rsp_a_ff;
   assign rsp_vertex_b = rsp_b_ff;
   assign rsp_vertex_c = rsp_c_ff;
   assign rsp_last_of_cell = rsp_last_ff;

   a_req_buffered: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> pend_valid_ff)
      else $error("accepted request not held in buffer");

   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (2'(emit_idx_ff) < num_ff))
      else $error("emit index beyond primitive count");

   a_point_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_prim_kind == ght_pkg::PRIM_POINT) |->
      (rsp_vertex_b == 16'd0 && rsp_vertex_c == 16'd0))
      else $error("point carries extra vertices");

   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      map_we |-> (state_ff == ST_IDLE))
      else $error("flag write while a cell is at work");

endmodule

// ===== dv/grid_hole_aware_tesselator_tb.sv =====
// self-checking testbench of the grid hole aware tesselator, with scoreboard and drivers
module grid_hole_aware_tesselator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAP_SIZE = 65536;
   localparam int CYCLE_LIMIT = 800000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] a;
      logic [15:0] b;
      logic [15:0] c;
      logic        last;
   } prim_type;

   class tess_scoreboard;
      bit          flags[MAP_SIZE];
      bit          written[MAP_SIZE];
      int unsigned regs[7];
      prim_type    pending[$];
      int          errors;

      function new();
         regs = '{256, 256, 0, 1, 0, 1, 256};
         errors = 0;
      endfunction

      function bit flag(int unsigned i);
         return (i < MAP_SIZE) ? flags[i] : 1'b0;
      endfunction

      // every node the block reads for a cell, neighbors clamped as in the datapath
      function void cell_nodes(logic [15:0] cell_num, ref int unsigned nodes[$]);
         int unsigned gr, gc, cs, row, col, lastr, lastc, nrow, ncol, prow, pcol;
         nodes.delete();
         gr = (regs[0] > ght_pkg::MAX_ROWS_DEF) ? ght_pkg::MAX_ROWS_DEF : regs[0];
         gc = (regs[1] > ght_pkg::MAX_COLS_DEF) ? ght_pkg::MAX_COLS_DEF : regs[1];
         cs = regs[6];
         if (gr == 0 || gc == 0 || cs == 0) return;
         row = (cell_num / cs) * regs[3] + regs[2];
         col = (cell_num % cs) * regs[5] + regs[4];
         lastr = gr - 1;
         lastc = gc - 1;
         if (row > lastr || col > lastc) return;
         nrow = row + regs[3];
         if (nrow > lastr) nrow = lastr;
         ncol = col + regs[5];
         if (ncol > lastc) ncol = lastc;
         prow = (row >= regs[3]) ? row - regs[3] : 0;
         pcol = (col >= regs[5]) ? col - regs[5] : 0;
         nodes.push_back(row * gc + col);
         nodes.push_back(row * gc + ncol);
         nodes.push_back(nrow * gc + col);
         nodes.push_back(nrow * gc + ncol);
         nodes.push_back(prow * gc + col);
         nodes.push_back(row * gc + pcol);
         nodes.push_back(prow * gc + ncol);
         nodes.push_back(nrow * gc + pcol);
      endfunction

      function void note_request(logic op, logic [15:0] idx, logic def, logic [15:0] cell_num);
         int unsigned gr, gc, cs, row, col, lastr, lastc, nrow, ncol, prow, pcol;
         int unsigned c11, c12, c21, c22;
         bit lrow, lcol, d11, d12, d21, d22, d01, d10, d02, d20, pre_r, pre_c;
         int n;
         prim_type out[$];
         if (op == ght_pkg::OP_LOAD) begin
            flags[idx] = def;
            written[idx] = 1'b1;
            return;
         end
         gr = (regs[0] > ght_pkg::MAX_ROWS_DEF) ? ght_pkg::MAX_ROWS_DEF : regs[0];
         gc = (regs[1] > ght_pkg::MAX_COLS_DEF) ? ght_pkg::MAX_COLS_DEF : regs[1];
         cs = regs[6];
         if (gr == 0 || gc == 0 || cs == 0) return;
         row = (cell_num / cs) * regs[3] + regs[2];
         col = (cell_num % cs) * regs[5] + regs[4];
         lastr = gr - 1;
         lastc = gc - 1;
         if (row > lastr || col > lastc) return;
         lrow = (row == lastr);
         lcol = (col == lastc);
         nrow = row + regs[3];
         if (nrow > lastr) nrow = lastr;
         ncol = col + regs[5];
         if (ncol > lastc) ncol = lastc;
         c11 = row * gc + col;
         c12 = row * gc + ncol;
         c21 = nrow * gc + col;
         c22 = nrow * gc + ncol;
         d11 = flag(c11);
         d12 = lcol ? 1'b0 : flag(c12);
         d21 = lrow ? 1'b0 : flag(c21);
         d22 = (lrow || lcol) ? 1'b0 : flag(c22);
         n = d11 + d12 + d21 + d22;
         if (n > 2) begin
            if (n == 4) begin
               out.push_back('{ght_pkg::PRIM_TRI, c21[15:0], c22[15:0], c11[15:0], 1'b0});
               out.push_back('{ght_pkg::PRIM_TRI, c11[15:0], c22[15:0], c12[15:0], 1'b0});
            end else if (!d11)
               out.push_back('{ght_pkg::PRIM_TRI, c21[15:0], c22[15:0], c12[15:0], 1'b0});
            else if (!d12)
               out.push_back('{ght_pkg::PRIM_TRI, c21[15:0], c22[15:0], c11[15:0], 1'b0});
            else if (!d21)
               out.push_back('{ght_pkg::PRIM_TRI, c11[15:0], c22[15:0], c12[15:0], 1'b0});
            else
               out.push_back('{ght_pkg::PRIM_TRI, c11[15:0], c21[15:0], c12[15:0], 1'b0});
         end else if (n > 0 && d11) begin
            pre_r = (row >= regs[3]);
            pre_c = (col >= regs[5]);
            prow = pre_r ? row - regs[3] : 0;
            pcol = pre_c ? col - regs[5] : 0;
            d01 = pre_r ? flag(prow * gc + col) : 1'b0;
            d10 = pre_c ? flag(row * gc + pcol) : 1'b0;
            if (n == 1) begin
               if (!d01 && !d10)
                  out.push_back('{ght_pkg::PRIM_POINT, c11[15:0], 16'd0, 16'd0, 1'b0});
            end else if (d12 && !d01) begin
               d02 = (!pre_r || lcol) ? 1'b0 : flag(prow * gc + ncol);
               if (!d02)
                  out.push_back('{ght_pkg::PRIM_LINE, c11[15:0], c12[15:0], 16'd0, 1'b0});
            end else if (d21 && !d10) begin
               d20 = (lrow || !pre_c) ? 1'b0 : flag(nrow * gc + pcol);
               if (!d20)
                  out.push_back('{ght_pkg::PRIM_LINE, c11[15:0], c21[15:0], 16'd0, 1'b0});
            end
         end
         if (out.size() > 0) out[out.size()-1].last = 1'b1;
         foreach (out[i]) pending.push_back(out[i]);
      endfunction

      function void check(prim_type got);
         prim_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected primitive %p", got);
            return;
         end
         want = pending.pop_front();
         if (got.kind !== want.kind || got.a !== want.a || got.b !== want.b ||
             got.c !== want.c || got.last !== want.last) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_opcode = 1'b0;
   logic [15:0] req_node_index = '0;
   logic        req_node_defined = 1'b0;
   logic [15:0] req_cell_number = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_prim_kind;
   logic [15:0] rsp_vertex_a, rsp_vertex_b, rsp_vertex_c;
   logic        rsp_last_of_cell;
   logic        csr_we = 1'b0;
   logic [ght_pkg::CFG_IDX_W-1:0] csr_index = '0;
   logic [ght_pkg::CFG_W-1:0]     csr_wdata = '0;

   tess_scoreboard sb = new();
   int send_idle = 24;
   int recv_idle = 70;
   int cycles = 0;

   grid_hole_aware_tesselator dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check('{rsp_prim_kind, rsp_vertex_a, rsp_vertex_b, rsp_vertex_c, rsp_last_of_cell});
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
   end

   task automatic send(logic op, logic [15:0] idx, logic def, logic [15:0] cell_num);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_node_index <= idx;
      req_node_defined <= def;
      req_cell_number <= cell_num;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(op, idx, def, cell_num);
   endtask

   // load any node the cell reads that was never written, then send the cell
   task automatic send_cell(logic [15:0] cell_num);
      int unsigned nodes[$];
      sb.cell_nodes(cell_num, nodes);
      foreach (nodes[i]) begin
         if (!sb.written[nodes[i]])
            send(ght_pkg::OP_LOAD, nodes[i][15:0], 1'($urandom), 16'($urandom));
      end
      send(ght_pkg::OP_CELL, 16'($urandom), 1'($urandom), cell_num);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [ght_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[ght_pkg::CFG_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      sb.regs[idx] = (idx >= ght_pkg::REG_ROW_FIRST && idx <= ght_pkg::REG_COL_STRIDE)
                     ? (val & 8'hff) : (val & 9'h1ff);
   endtask

   task automatic set_grid(int unsigned v[7]);
      csr_write(ght_pkg::REG_GRID_ROWS, v[0]);
      csr_write(ght_pkg::REG_GRID_COLS, v[1]);
      csr_write(ght_pkg::REG_ROW_FIRST, v[2]);
      csr_write(ght_pkg::REG_ROW_STRIDE, v[3]);
      csr_write(ght_pkg::REG_COL_FIRST, v[4]);
      csr_write(ght_pkg::REG_COL_STRIDE, v[5]);
      csr_write(ght_pkg::REG_COLS_SAMPLED, v[6]);
   endtask

   // 4x4 grid, node i takes bit i of the mask
   task automatic load_mask(logic [15:0] mask);
      for (int i = 0; i < 16; i++) send(ght_pkg::OP_LOAD, i[15:0], mask[i], 16'($urandom));
   endtask

   int unsigned phases[9][7] = '{
      '{256, 256, 0, 1, 0, 1, 256},
      '{8, 8, 0, 1, 0, 1, 8},
      '{16, 12, 1, 2, 0, 3, 4},
      '{511, 300, 255, 255, 255, 255, 511},
      '{1, 1, 0, 0, 0, 0, 1},
      '{0, 5, 0, 1, 0, 1, 5},
      '{6, 6, 0, 0, 2, 0, 3},
      '{10, 10, 3, 1, 2, 2, 0},
      '{200, 256, 0, 7, 0, 5, 40}
   };

   initial begin
      int unsigned gr, gc, density;
      logic [15:0] masks[9] = '{16'hffff, 16'h0033, 16'h0032, 16'h0031, 16'h0023,
                                16'h0013, 16'h0001, 16'h0003, 16'h0011};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corner patterns on a small grid
      set_grid('{4, 4, 0, 1, 0, 1, 4});
      foreach (masks[m]) begin
         load_mask(masks[m]);
         send_cell(16'd0);
         if (m == 0) begin
            send_cell(16'd3);
            send_cell(16'd12);
            send_cell(16'd15);
            send_cell(16'd16);
            send_cell(16'hffff);
         end
      end
      drain();

      for (int p = 0; p < 9; p++) begin
         send_idle = (p < 3) ? 24 : (p < 6) ? 70 : 0;
         recv_idle = (p < 3) ? 70 : (p < 6) ? 24 : 0;
         set_grid(phases[p]);
         gr = (phases[p][0] > 256) ? 256 : phases[p][0];
         gc = (phases[p][1] > 256) ? 256 : phases[p][1];
         if (gr == 0) gr = 1;
         if (gc == 0) gc = 1;
         density = $urandom_range(30, 90);
         for (int k = 0; k < 25; k++) begin
            if ($urandom_range(0, 99) < 30) begin
               if ($urandom_range(0, 9) == 0)
                  send(ght_pkg::OP_LOAD, 16'($urandom), 1'($urandom), 16'($urandom));
               else
                  send(ght_pkg::OP_LOAD, 16'($urandom_range(0, gr * gc - 1)),
                       ($urandom_range(0, 99) < density), 16'($urandom));
            end else if ($urandom_range(0, 9) == 0) begin
               send_cell(16'($urandom));
            end else if ($urandom_range(0, 9) < 2) begin
               send_cell(16'($urandom_range(0, (phases[p][6] + 1) * 16)));
            end else begin
               send_cell(16'($urandom_range(0, 11)));
            end
         end
         drain();
      end

      if (sb.pending.size() != 0) sb.errors++;
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
design/ght_pkg.sv
design/ght_div.sv
design/grid_hole_aware_tesselator.sv
dv/grid_hole_aware_tesselator_tb.sv
